// ===== hw/rtl/bgcd_pkg.sv =====
// Shared constants, command codes, status type and a trailing-zero helper for the binary GCD block.
package bgcd_pkg;

    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int SHIFT_W = 3;

    typedef logic [WIDTH-1:0]   word_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZERO,
        OP_COMMON,
        OP_STRIP_X,
        OP_STRIP_Y,
        OP_SUB,
        OP_FINAL
    } op_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic both_even;
        logic x_even;
        logic y_even;
    } status_t;

    // Trailing zeros of a nibble, saturating at four.
    function automatic shift_t tz4(input logic [3:0] v);
        shift_t n;
        if (v[0])
        begin
            n = 3'd0;
        end
        else if (v[1])
        begin
            n = 3'd1;
        end
        else if (v[2])
        begin
            n = 3'd2;
        end
        else if (v[3])
        begin
            n = 3'd3;
        end
        else
        begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/bgcd_if.sv =====
// Valid/ready channel interfaces for operand items and result items.
interface bgcd_in_if;
    import bgcd_pkg::*;

    logic  valid;
    logic  ready;
    word_t operand_a;
    word_t operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface bgcd_out_if;
    import bgcd_pkg::*;

    logic  valid;
    logic  ready;
    word_t divisor;
    logic  coprime;

    modport source (output valid, output divisor, output coprime, input ready);
    modport sink (input valid, input divisor, input coprime, output ready);
endinterface

// ===== hw/rtl/binary_gcd.sv =====
// Binary GCD block: one operand pair in, one divisor and coprime flag out.
// After an operand pair is taken, a zero operand sends the other straight to the result register;
// otherwise the block removes the common power of two and strips the first operand in nibble
// steps, then alternates subtract passes and nibble strip steps; a waiting result adds stalls.
// Throughput: one item at a time; the next item is taken once the result is in its register.
// Reset clears the state machine and the result valid flag; the operand registers are not reset.
module binary_gcd (
    input logic        clk,
    input logic        rst_n,
    bgcd_in_if.sink    operands,
    bgcd_out_if.source result
);
    import bgcd_pkg::*;

    op_t     op;
    status_t status;

    bgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .op        (op)
    );

    bgcd_datapath u_datapath (
        .clk       (clk),
        .op        (op),
        .operand_a (operands.operand_a),
        .operand_b (operands.operand_b),
        .status    (status),
        .divisor   (result.divisor),
        .coprime   (result.coprime)
    );

`ifndef SYNTHESIS
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> !$rose(result.valid))
        else $error("result item appeared one cycle after an operand item was taken");

    a_coprime_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.coprime == (result.divisor == word_t'(1))))
        else $error("coprime flag disagrees with divisor");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> !operands.ready)
        else $error("operand item taken while the previous one is in progress");
`endif

endmodule

// ===== hw/rtl/bgcd_datapath.sv =====
// Operand registers, shifters, subtractors and result register of the binary GCD block.
module bgcd_datapath (
    input  logic             clk,
    input  bgcd_pkg::op_t    op,
    input  bgcd_pkg::word_t  operand_a,
    input  bgcd_pkg::word_t  operand_b,
    output bgcd_pkg::status_t status,
    output bgcd_pkg::word_t  divisor,
    output logic             coprime
);
    import bgcd_pkg::*;

    word_t  x_reg, x_next;
    word_t  y_reg, y_next;
    count_t common_reg, common_next;
    word_t  divisor_reg, divisor_next;
    logic   coprime_reg, coprime_next;

    shift_t            tz_x, tz_y, tz_xy;
    logic [WIDTH:0]    y_minus_x;
    word_t             x_minus_y;
    logic              x_gt_y;

    assign tz_x  = tz4(x_reg[3:0]);
    assign tz_y  = tz4(y_reg[3:0]);
    assign tz_xy = tz4(x_reg[3:0] | y_reg[3:0]);

    assign y_minus_x = {1'b0, y_reg} - {1'b0, x_reg};
    assign x_minus_y = x_reg - y_reg;
    assign x_gt_y    = y_minus_x[WIDTH];

    assign status.x_zero    = (x_reg == '0);
    assign status.y_zero    = (y_reg == '0);
    assign status.both_even = ~(x_reg[0] | y_reg[0]);
    assign status.x_even    = ~x_reg[0];
    assign status.y_even    = ~y_reg[0];

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        common_next  = common_reg;
        divisor_next = divisor_reg;
        coprime_next = coprime_reg;
        case (op)
            OP_LOAD:
            begin
                x_next      = operand_a;
                y_next      = operand_b;
                common_next = '0;
            end
            OP_ZERO:
            begin
                divisor_next = (x_reg == '0) ? y_reg : x_reg;
                coprime_next = ((x_reg == '0) ? y_reg : x_reg) == word_t'(1);
            end
            OP_COMMON:
            begin
                x_next      = x_reg >> tz_xy;
                y_next      = y_reg >> tz_xy;
                common_next = common_reg + count_t'(tz_xy);
            end
            OP_STRIP_X:
            begin
                x_next = x_reg >> tz_x;
            end
            OP_STRIP_Y:
            begin
                y_next = y_reg >> tz_y;
            end
            OP_SUB:
            begin
                if (x_gt_y)
                begin
                    x_next = y_reg;
                    y_next = x_minus_y;
                end
                else
                begin
                    y_next = y_minus_x[WIDTH-1:0];
                end
            end
            OP_FINAL:
            begin
                divisor_next = x_reg << common_reg;
                coprime_next = (x_reg == word_t'(1)) && (common_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        common_reg  <= common_next;
        divisor_reg <= divisor_next;
        coprime_reg <= coprime_next;
    end

    assign divisor = divisor_reg;
    assign coprime = coprime_reg;

endmodule

// ===== hw/rtl/bgcd_ctrl.sv =====
// Sequencing state machine of the binary GCD block.
module bgcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bgcd_pkg::status_t status,
    output bgcd_pkg::op_t     op
);
    import bgcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_COMMON,
        S_STRIP_X,
        S_STRIP_Y,
        S_SUB,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   result_load;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_free    = ~out_valid_reg | out_ready;
    assign out_valid   = out_valid_reg;
    assign result_load = (op == OP_ZERO) || (op == OP_FINAL);

    always_comb
    begin
        op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                end
            end
            S_CHECK:
            begin
                if ((status.x_zero || status.y_zero) && out_free)
                begin
                    op = OP_ZERO;
                end
            end
            S_COMMON:
            begin
                if (status.both_even)
                begin
                    op = OP_COMMON;
                end
            end
            S_STRIP_X:
            begin
                if (status.x_even)
                begin
                    op = OP_STRIP_X;
                end
            end
            S_STRIP_Y:
            begin
                if (!status.y_zero && status.y_even)
                begin
                    op = OP_STRIP_Y;
                end
            end
            S_SUB:
            begin
                op = OP_SUB;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    op = OP_FINAL;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (status.x_zero || status.y_zero)
                    begin
                        if (out_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_COMMON;
                    end
                end
                S_COMMON:
                begin
                    if (!status.both_even)
                    begin
                        state_reg <= S_STRIP_X;
                    end
                end
                S_STRIP_X:
                begin
                    if (!status.x_even)
                    begin
                        state_reg <= S_STRIP_Y;
                    end
                end
                S_STRIP_Y:
                begin
                    if (status.y_zero)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (!status.y_even)
                    begin
                        state_reg <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    state_reg <= S_STRIP_Y;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
